// File: hdl/jtc_pkg.sv
package jtc_pkg;

  // Command codes carried in the command field.
  localparam logic [2:0] CMD_APPEND     = 3'd0;
  localparam logic [2:0] CMD_REMOVE_ID  = 3'd1;
  localparam logic [2:0] CMD_REMOVE_PID = 3'd2;
  localparam logic [2:0] CMD_ID_TO_PID  = 3'd3;
  localparam logic [2:0] CMD_PID_TO_ID  = 3'd4;
  localparam logic [2:0] CMD_FETCH_ID   = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // The entry count field saturates at this value.
  localparam logic [4:0] TOTAL_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  job_id;
    logic [21:0] proc_id;
    logic [1:0]  job_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_id;
    logic [21:0] found_pid;
    logic [1:0]  found_state;
    logic [4:0]  entry_total;
  } out_item_t;

  // One stored job record.
  typedef struct packed {
    logic [7:0]  job_id;
    logic [21:0] proc_id;
    logic [1:0]  job_state;
  } rec_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        cmp_en;
    logic        by_pid;
    logic [7:0]  key_id;
    logic [21:0] key_pid;
    logic        shift_en;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } seq_state_t;

endpackage

// File: hdl/jtc_cell.sv
// One table slot. It holds a record, registers its own key compare when a
// command is taken, and passes the first-match flag and record down the row.
module jtc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  jtc_pkg::cell_ctl_t ctl,
  input  logic              live,
  input  logic              wr_en,
  input  jtc_pkg::rec_t     wr_rec,
  input  jtc_pkg::rec_t     nb_rec,
  input  logic              hit_in,
  input  jtc_pkg::rec_t     found_in,
  output logic              hit_out,
  output jtc_pkg::rec_t     found_out,
  output jtc_pkg::rec_t     rec_out
);

  jtc_pkg::rec_t rec_r;
  logic          mt_r;
  logic          key_eq;

  // Key compare against the incoming command.
  assign key_eq = ctl.by_pid ? (rec_r.proc_id == ctl.key_pid)
                             : (rec_r.job_id == ctl.key_id);

  // The match bit is captured in the cycle the command transfers in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mt_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      mt_r <= live & key_eq;
    end
  end

  // A removal pulls the neighbor's record into every slot at or after the
  // first match; an append writes the slot just past the last valid one.
  always_ff @(posedge clk) begin
    if (ctl.shift_en && (hit_in || mt_r)) begin
      rec_r <= nb_rec;
    end else if (wr_en) begin
      rec_r <= wr_rec;
    end
  end

  // Only the first matching slot places its record on the found chain.
  assign hit_out   = hit_in | mt_r;
  assign found_out = (!hit_in && mt_r) ? rec_r : found_in;
  assign rec_out   = rec_r;

endmodule

// File: hdl/job_table_with_compaction_core.sv
// Job table: a packed list of up to TABLE_DEPTH job records held in a row
// of slot cells. Each command runs as follows: in the cycle it transfers
// in, every cell registers the compare of its record with the key; then,
// in the execute state and once the result register is free, the
// first-match flag ripples down the row, the matched record is picked up,
// a removal shifts later records down one slot, an append fills the slot
// after the last one, and the result is loaded into the output register.
// No new command is taken until the sequencer is back in the idle state
// after that load; a stalled result holds back only the following command's execute step.
module job_table_with_compaction_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jtc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jtc_pkg::out_item_t out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  jtc_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  jtc_pkg::in_item_t   item_r;
  logic                out_valid_r, out_valid_nxt;
  jtc_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                in_xfer;
  logic                out_free;
  logic                adv;
  logic                is_append;
  logic                is_remove;
  logic                is_search;
  logic                full;
  jtc_pkg::cell_ctl_t  ctl;

  logic                hit [0:TABLE_DEPTH];
  jtc_pkg::rec_t       found [0:TABLE_DEPTH];
  jtc_pkg::rec_t       rec_q [0:TABLE_DEPTH];

  assign in_stall = (state_r != jtc_pkg::ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign adv      = (state_r == jtc_pkg::ST_EXEC) & out_free;

  assign is_append = (item_r.command == jtc_pkg::CMD_APPEND);
  assign is_remove = (item_r.command == jtc_pkg::CMD_REMOVE_ID) ||
                     (item_r.command == jtc_pkg::CMD_REMOVE_PID);
  assign is_search = is_remove ||
                     (item_r.command == jtc_pkg::CMD_ID_TO_PID) ||
                     (item_r.command == jtc_pkg::CMD_PID_TO_ID) ||
                     (item_r.command == jtc_pkg::CMD_FETCH_ID);
  assign full      = (fill_r == CW'(TABLE_DEPTH));

  // Broadcast control: compare on the incoming command, shift on removal.
  always_comb begin
    ctl.cmp_en   = in_xfer;
    ctl.by_pid   = (in_data.command == jtc_pkg::CMD_REMOVE_PID) ||
                   (in_data.command == jtc_pkg::CMD_PID_TO_ID);
    ctl.key_id   = in_data.job_id;
    ctl.key_pid  = in_data.proc_id;
    ctl.shift_en = adv & is_remove & hit[TABLE_DEPTH];
  end

  // Ends of the row.
  assign hit[0]             = 1'b0;
  assign found[0]           = '0;
  assign rec_q[TABLE_DEPTH] = '0;

  // The row of slot cells.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    jtc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .live      (CW'(k) < fill_r),
      .wr_en     (adv & is_append & ~full & (fill_r == CW'(k))),
      .wr_rec    ({item_r.job_id, item_r.proc_id, item_r.job_state}),
      .nb_rec    (rec_q[k+1]),
      .hit_in    (hit[k]),
      .found_in  (found[k]),
      .hit_out   (hit[k+1]),
      .found_out (found[k+1]),
      .rec_out   (rec_q[k])
    );
  end

  // Sequencer and result formation.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      jtc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = jtc_pkg::ST_EXEC;
        end
      end
      jtc_pkg::ST_EXEC: begin
        if (adv) begin
          state_nxt                = jtc_pkg::ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = jtc_pkg::STAT_OK;
          out_data_nxt.found_id    = '0;
          out_data_nxt.found_pid   = '0;
          out_data_nxt.found_state = '0;
          if (is_append) begin
            if (full) begin
              out_data_nxt.status = jtc_pkg::STAT_FULL;
            end else begin
              fill_nxt = fill_r + CW'(1);
            end
          end else if (is_search) begin
            if (!hit[TABLE_DEPTH]) begin
              out_data_nxt.status = jtc_pkg::STAT_MISSING;
            end else begin
              out_data_nxt.found_id    = found[TABLE_DEPTH].job_id;
              out_data_nxt.found_pid   = found[TABLE_DEPTH].proc_id;
              out_data_nxt.found_state = found[TABLE_DEPTH].job_state;
              if (is_remove) begin
                fill_nxt = fill_r - CW'(1);
              end
            end
          end
          out_data_nxt.entry_total =
            (32'(fill_nxt) > 32'(jtc_pkg::TOTAL_MAX)) ? jtc_pkg::TOTAL_MAX
                                                      : 5'(fill_nxt);
        end
      end
      default: begin
        state_nxt = jtc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jtc_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/jtc_checker.sv
// Port-level checks for the job table.
module jtc_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input jtc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input jtc_pkg::out_item_t out_data
);

  localparam logic [4:0] SAT_TOTAL =
    (TABLE_DEPTH > 31) ? jtc_pkg::TOTAL_MAX : 5'(TABLE_DEPTH);

  // A held result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The table is busy for the cycle after a command transfers in.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while the previous one is in progress");

  // A full answer means the count is at the table depth, saturated at TOTAL_MAX.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == jtc_pkg::STAT_FULL) |->
      out_data.entry_total == SAT_TOTAL)
    else $error("full status with a table that is not full");

  // Failed commands report no record.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == jtc_pkg::STAT_FULL) ||
                  (out_data.status == jtc_pkg::STAT_MISSING)) |->
      (out_data.found_id == '0) && (out_data.found_pid == '0) &&
      (out_data.found_state == '0))
    else $error("record reported with a failing status");

  // The count never exceeds the table size.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_total <= SAT_TOTAL)
    else $error("entry count above table depth");

endmodule

bind job_table_with_compaction_core jtc_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_jtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
